// ===== rtl/core/cdna_pkg.sv =====
`default_nettype none
package cdna_pkg;

	localparam logic [6:0] MAX_DYN_ID  = 7'd125;
	localparam logic [4:0] UID_BYTES   = 5'd16;
	localparam logic [4:0] STAGE_LONG  = 5'd6;
	localparam logic [4:0] STAGE_SHORT = 5'd4;
	localparam logic [4:0] STAGE2_LEN  = 5'd12;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [6:0] OWN_RESET   = 7'd1;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_ONLINE  = 2'd1,
		OP_OFFLINE = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		OUT_IGNORED  = 3'd0,
		OUT_ECHO     = 3'd1,
		OUT_ALLOC    = 3'd2,
		OUT_NO_FREE  = 3'd3,
		OUT_PRESENCE = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		STG_NONE  = 2'd0,
		STG_ONE   = 2'd1,
		STG_TWO   = 2'd2,
		STG_THREE = 2'd3
	} stage_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_OWN_ID  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ISSUE,
		S_DRAIN,
		S_REC,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_LOOKUP,
		PH_PREF,
		PH_SCAN
	} phase_t;

	typedef struct packed {
		logic       vld;
		logic       lookup;
		logic       pref;
		logic       last;
		logic [6:0] id;
		logic       hit;
		logic [6:0] node;
	} tok_t;

endpackage
`default_nettype wire

// ===== rtl/core/can_dynamic_node_id_allocator_top.sv =====
// channel   dir   handshake                 payload
// in        in    in_valid / in_ready       opcode now_ms source_node is_broadcast first_part
//                                           preferred_node chunk_len uid_chunk
// out       out   out_valid / out_ready     outcome reply_node_id reply_uid_len
//                                           reply_uid_low reply_uid_high
// cfg       in    psel penable pwrite       paddr pwdata prdata pready
//
// one word at a time: a presence event or partial stage runs exec then emit; a final stage
// runs issue, drain, record and emit, issue streaming the lookup token, the preferred id and
// the candidate ids one a cycle through the chain of table cells
// reset clears collection and table count and leaves only the presence bit of id 1 set; no clearing pass
// in_ready is high only while idle; a waiting output word stalls the emit step only
`default_nettype none
module can_dynamic_node_id_allocator_top #(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_ready,
	input  wire logic [1:0]   opcode,
	input  wire logic [31:0]  now_ms,
	input  wire logic [6:0]   source_node,
	input  wire logic         is_broadcast,
	input  wire logic         first_part,
	input  wire logic [6:0]   preferred_node,
	input  wire logic [4:0]   chunk_len,
	input  wire logic [47:0]  uid_chunk,
	output      logic         out_valid,
	input  wire logic         out_ready,
	output      logic [2:0]   outcome,
	output      logic [6:0]   reply_node_id,
	output      logic [4:0]   reply_uid_len,
	output      logic [63:0]  reply_uid_low,
	output      logic [63:0]  reply_uid_high,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output      logic [31:0]  prdata,
	output      logic         pready
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [127:0] ONLINE_RESET = 128'd1 << cdna_pkg::OWN_RESET;

	cdna_pkg::state_t state_q, state_nx;
	cdna_pkg::phase_t phase_q;

	logic [1:0]   op_q;
	logic [31:0]  now_q;
	logic [6:0]   src_q;
	logic         bc_q;
	logic         fp_q;
	logic [6:0]   pref_q;
	logic [4:0]   len_q;
	logic [47:0]  chunk_q;

	logic [127:0] coll_q;
	logic [4:0]   coll_len_q;
	logic [6:0]   pend_q;
	logic [31:0]  last_ms_q;
	logic [127:0] online_q;
	logic [CW-1:0] count_q;
	logic [6:0]   scan_q;
	logic [6:0]   cand_q;
	logic [15:0]  tmo_q;
	logic [6:0]   own_q;

	logic         dec_q;
	logic         rec_q;
	logic [6:0]   sel_q;

	logic [2:0]   res_out_q;
	logic [6:0]   res_id_q;
	logic [4:0]   res_len_q;
	logic [127:0] res_uid_q;

	logic         out_vld_q;
	logic [2:0]   out_outcome_q;
	logic [6:0]   out_id_q;
	logic [4:0]   out_len_q;
	logic [127:0] out_uid_q;

	// request decode
	logic         tmo_hit;
	logic         req_ok;
	logic         len_ok;
	logic [4:0]   eff_len;
	logic [127:0] eff_uid;
	cdna_pkg::stage_t stage, expected;
	logic [47:0]  chunk_m;
	logic [127:0] placed;
	logic [127:0] new_uid;
	logic [4:0]   new_len;
	logic         stage_ok;
	logic         go_alloc;

	// chain
	cdna_pkg::tok_t tok [0:TABLE_ENTRIES];
	cdna_pkg::tok_t tok_iss;
	cdna_pkg::tok_t tok_x;
	logic           x_online;
	logic           pref_ok;
	logic           take;
	logic           free_slot;
	logic           emit_go;
	logic           cfg_wr;

	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign in_ready  = (state_q == cdna_pkg::S_IDLE);
	assign free_slot = (count_q < CW'(TABLE_ENTRIES));
	assign emit_go   = (state_q == cdna_pkg::S_EMIT) && (!out_vld_q || out_ready);

	always_comb begin
		unique case (cdna_pkg::reg_idx_t'(paddr[2]))
			cdna_pkg::REG_TIMEOUT: prdata = {16'd0, tmo_q};
			cdna_pkg::REG_OWN_ID:  prdata = {25'd0, own_q};
			default:               prdata = 32'd0;
		endcase
	end

	always_comb begin
		tmo_hit = ({1'b0, now_q} > ({1'b0, last_ms_q} + {17'd0, tmo_q}));
		req_ok  = (op_q == cdna_pkg::OP_REQUEST) && bc_q && (src_q == 7'd0) &&
			(len_q <= cdna_pkg::UID_BYTES);
		len_ok  = (len_q == cdna_pkg::STAGE_LONG) || (len_q == cdna_pkg::STAGE_SHORT);
		eff_len = tmo_hit ? 5'd0 : coll_len_q;
		eff_uid = tmo_hit ? 128'd0 : coll_q;
		if (fp_q) begin
			stage = cdna_pkg::STG_ONE;
		end else if (len_q == cdna_pkg::STAGE_LONG) begin
			stage = cdna_pkg::STG_TWO;
		end else begin
			stage = cdna_pkg::STG_THREE;
		end
		if (eff_len == 5'd0) begin
			expected = cdna_pkg::STG_ONE;
		end else if (eff_len == cdna_pkg::STAGE_LONG) begin
			expected = cdna_pkg::STG_TWO;
		end else if (eff_len == cdna_pkg::STAGE2_LEN) begin
			expected = cdna_pkg::STG_THREE;
		end else begin
			expected = cdna_pkg::STG_NONE;
		end
		chunk_m = (len_q == cdna_pkg::STAGE_LONG) ? chunk_q : {16'd0, chunk_q[31:0]};
		if (eff_len == cdna_pkg::STAGE_LONG) begin
			placed = {80'd0, chunk_m} << 48;
		end else if (eff_len == cdna_pkg::STAGE2_LEN) begin
			placed = {80'd0, chunk_m} << 96;
		end else begin
			placed = {80'd0, chunk_m};
		end
		new_uid  = eff_uid | placed;
		new_len  = eff_len + len_q;
		stage_ok = req_ok && len_ok && (stage == expected);
		go_alloc = stage_ok && (new_len == cdna_pkg::UID_BYTES);
	end

	// token issue into the chain
	always_comb begin
		tok_iss = '0;
		if (state_q == cdna_pkg::S_ISSUE) begin
			tok_iss.vld = 1'b1;
			unique case (phase_q)
				cdna_pkg::PH_LOOKUP: tok_iss.lookup = 1'b1;
				cdna_pkg::PH_PREF: begin
					tok_iss.pref = 1'b1;
					tok_iss.id   = pend_q;
					tok_iss.last = (scan_q > cdna_pkg::MAX_DYN_ID);
				end
				cdna_pkg::PH_SCAN: begin
					tok_iss.id   = cand_q;
					tok_iss.last = (cand_q == cdna_pkg::MAX_DYN_ID);
				end
				default: tok_iss.vld = 1'b0;
			endcase
		end
	end

	assign tok[0] = tok_iss;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		cdna_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ent_valid (CW'(i) < count_q),
			.wr_en     ((state_q == cdna_pkg::S_REC) && dec_q && rec_q &&
				(count_q == CW'(i))),
			.wr_uid    (coll_q),
			.wr_node   (sel_q),
			.key_uid   (coll_q),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

	always_comb begin
		tok_x    = tok[TABLE_ENTRIES];
		x_online = online_q[tok_x.id] || (tok_x.id == own_q);
		pref_ok  = (pend_q != 7'd0) && (pend_q <= cdna_pkg::MAX_DYN_ID);
		if (tok_x.lookup) begin
			take = tok_x.hit;
		end else if (tok_x.pref) begin
			take = pref_ok && !tok_x.hit && !x_online;
		end else begin
			take = !tok_x.hit && !x_online;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cdna_pkg::S_IDLE:  if (in_valid) state_nx = cdna_pkg::S_EXEC;
			cdna_pkg::S_EXEC:  state_nx = go_alloc ? cdna_pkg::S_ISSUE : cdna_pkg::S_EMIT;
			cdna_pkg::S_ISSUE: if (tok_iss.last) state_nx = cdna_pkg::S_DRAIN;
			cdna_pkg::S_DRAIN: if (tok_x.vld && tok_x.last) state_nx = cdna_pkg::S_REC;
			cdna_pkg::S_REC:   state_nx = cdna_pkg::S_EMIT;
			cdna_pkg::S_EMIT:  if (!out_vld_q || out_ready) state_nx = cdna_pkg::S_IDLE;
			default:           state_nx = cdna_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdna_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= opcode;
			now_q   <= now_ms;
			src_q   <= source_node;
			bc_q    <= is_broadcast;
			fp_q    <= first_part;
			pref_q  <= preferred_node;
			len_q   <= chunk_len;
			chunk_q <= uid_chunk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q      <= cdna_pkg::TIMEOUT_RESET;
			own_q      <= cdna_pkg::OWN_RESET;
			coll_q     <= '0;
			coll_len_q <= '0;
			pend_q     <= '0;
			last_ms_q  <= '0;
			online_q   <= ONLINE_RESET;
			count_q    <= '0;
			scan_q     <= 7'd1;
			cand_q     <= '0;
			phase_q    <= cdna_pkg::PH_LOOKUP;
			dec_q      <= 1'b0;
			rec_q      <= 1'b0;
			sel_q      <= '0;
			res_out_q  <= '0;
			res_id_q   <= '0;
			res_len_q  <= '0;
			res_uid_q  <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cdna_pkg::reg_idx_t'(paddr[2]))
					cdna_pkg::REG_TIMEOUT: tmo_q <= pwdata[15:0];
					cdna_pkg::REG_OWN_ID:  own_q <= pwdata[6:0];
					default: ;
				endcase
			end
			unique case (state_q)
				cdna_pkg::S_EXEC: begin
					res_out_q <= cdna_pkg::OUT_IGNORED;
					res_id_q  <= '0;
					res_len_q <= '0;
					res_uid_q <= '0;
					phase_q   <= cdna_pkg::PH_LOOKUP;
					dec_q     <= 1'b0;
					rec_q     <= 1'b0;
					if ((op_q == cdna_pkg::OP_ONLINE) || (op_q == cdna_pkg::OP_OFFLINE)) begin
						if (src_q != 7'd0) begin
							online_q[src_q] <= (op_q == cdna_pkg::OP_ONLINE);
							res_out_q       <= cdna_pkg::OUT_PRESENCE;
						end
					end else if (req_ok) begin
						if (tmo_hit || (len_ok && (stage != expected))) begin
							coll_q     <= '0;
							coll_len_q <= '0;
							pend_q     <= '0;
							last_ms_q  <= '0;
						end
						if (stage_ok) begin
							coll_q     <= new_uid;
							coll_len_q <= new_len;
							if (stage == cdna_pkg::STG_ONE) begin
								pend_q <= pref_q;
							end
							if (!go_alloc) begin
								last_ms_q <= now_q;
								res_out_q <= cdna_pkg::OUT_ECHO;
								res_len_q <= new_len;
								res_uid_q <= new_uid;
							end
						end
					end
				end
				cdna_pkg::S_ISSUE: begin
					unique case (phase_q)
						cdna_pkg::PH_LOOKUP: phase_q <= cdna_pkg::PH_PREF;
						cdna_pkg::PH_PREF: begin
							phase_q <= cdna_pkg::PH_SCAN;
							cand_q  <= scan_q;
						end
						cdna_pkg::PH_SCAN: cand_q <= cand_q + 7'd1;
						default: phase_q <= cdna_pkg::PH_LOOKUP;
					endcase
				end
				cdna_pkg::S_REC: begin
					if (dec_q && rec_q && free_slot) begin
						count_q <= count_q + CW'(1);
					end
					res_out_q  <= dec_q ? cdna_pkg::OUT_ALLOC : cdna_pkg::OUT_NO_FREE;
					res_id_q   <= dec_q ? sel_q : 7'd0;
					res_len_q  <= coll_len_q;
					res_uid_q  <= coll_q;
					coll_q     <= '0;
					coll_len_q <= '0;
					pend_q     <= '0;
					last_ms_q  <= '0;
				end
				default: ;
			endcase
			if (tok_x.vld && !dec_q && take) begin
				dec_q <= 1'b1;
				rec_q <= !tok_x.lookup;
				sel_q <= tok_x.lookup ? tok_x.node : tok_x.id;
				if (!tok_x.lookup && !tok_x.pref) begin
					scan_q <= tok_x.id + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_outcome_q <= res_out_q;
			out_id_q      <= res_id_q;
			out_len_q     <= res_len_q;
			out_uid_q     <= res_uid_q;
		end
	end

	assign out_valid      = out_vld_q;
	assign outcome        = out_outcome_q;
	assign reply_node_id  = out_id_q;
	assign reply_uid_len  = out_len_q;
	assign reply_uid_low  = out_uid_q[63:0];
	assign reply_uid_high = out_uid_q[127:64];

endmodule
`default_nettype wire

// ===== rtl/core/cdna_cell.sv =====
`default_nettype none
module cdna_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ent_valid,
	input  wire logic               wr_en,
	input  wire logic [127:0]       wr_uid,
	input  wire logic [6:0]         wr_node,
	input  wire logic [127:0]       key_uid,
	input  wire cdna_pkg::tok_t     tok_in,
	output      cdna_pkg::tok_t     tok_out
);

	logic [127:0]   uid_q;
	logic [6:0]     node_q;
	cdna_pkg::tok_t tok_q;
	cdna_pkg::tok_t tok_nx;
	logic           match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			uid_q  <= wr_uid;
			node_q <= wr_node;
		end
	end

	always_comb begin
		if (tok_in.lookup) begin
			match = ent_valid && (uid_q == key_uid) && (node_q != 7'd0);
		end else begin
			match = ent_valid && (node_q == tok_in.id);
		end
		tok_nx = tok_in;
		if (!tok_in.hit && match) begin
			tok_nx.hit  = 1'b1;
			tok_nx.node = node_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// ===== bench/can_dynamic_node_id_allocator_top_tb.sv =====
`default_nettype none
module can_dynamic_node_id_allocator_top_tb;

	typedef struct {
		cdna_pkg::opcode_t op;
		logic [31:0] ms;
		logic [6:0]  src;
		logic        bc;
		logic        fp;
		logic [6:0]  pref;
		logic [4:0]  len;
		logic [47:0] chunk;
	} request_t;

	typedef struct {
		cdna_pkg::outcome_t oc;
		logic [6:0]  id;
		logic [4:0]  len;
		logic [63:0] lo;
		logic [63:0] hi;
	} reply_t;

	class alloc_scoreboard;
		reply_t       due[$];
		int           errors;
		logic [127:0] uid;
		logic [4:0]   clen;
		logic [6:0]   ppref;
		logic [31:0]  last_ms;
		bit           online[128];
		logic [127:0] tab_uid[32];
		logic [6:0]   tab_node[32];
		int           tab_cnt;
		int           scan;
		logic [15:0]  tmo;
		logic [6:0]   own;

		function new();
			errors = 0;
			tmo = cdna_pkg::TIMEOUT_RESET;
			own = cdna_pkg::OWN_RESET;
			foreach (online[i]) online[i] = 0;
			online[cdna_pkg::OWN_RESET] = 1;
			tab_cnt = 0;
			scan = 1;
			restart();
		endfunction

		function void restart();
			uid = '0;
			clen = '0;
			ppref = '0;
			last_ms = '0;
		endfunction

		function bit id_free(int id);
			if (online[id] || id == own)
				return 0;
			for (int i = 0; i < tab_cnt; i++)
				if (tab_node[i] == id)
					return 0;
			return 1;
		endfunction

		function int pick_id();
			int id;
			for (int i = 0; i < tab_cnt; i++)
				if (tab_uid[i] == uid && tab_node[i] > 0)
					return tab_node[i];
			id = 0;
			if (ppref >= 1 && ppref <= cdna_pkg::MAX_DYN_ID && id_free(ppref))
				id = ppref;
			if (id == 0) begin
				for (int c = scan; c <= cdna_pkg::MAX_DYN_ID; c++)
					if (id_free(c)) begin
						scan = c + 1;
						id = c;
						break;
					end
				if (id == 0)
					return 0;
			end
			if (tab_cnt < 32) begin
				tab_uid[tab_cnt] = uid;
				tab_node[tab_cnt] = 7'(id);
				tab_cnt++;
			end
			return id;
		endfunction

		function void note(request_t r);
			reply_t e;
			cdna_pkg::stage_t stg;
			cdna_pkg::stage_t want;
			int id;
			e = '{cdna_pkg::OUT_IGNORED, 7'd0, 5'd0, 64'd0, 64'd0};
			if (r.op == cdna_pkg::OP_ONLINE || r.op == cdna_pkg::OP_OFFLINE) begin
				if (r.src != 0) begin
					online[r.src] = (r.op == cdna_pkg::OP_ONLINE);
					e.oc = cdna_pkg::OUT_PRESENCE;
				end
				due.push_back(e);
				return;
			end
			if (r.op != cdna_pkg::OP_REQUEST || !r.bc || r.src != 0 ||
					r.len > cdna_pkg::UID_BYTES) begin
				due.push_back(e);
				return;
			end
			if (longint'(r.ms) > longint'(last_ms) + longint'(tmo))
				restart();
			if (r.len != cdna_pkg::STAGE_LONG && r.len != cdna_pkg::STAGE_SHORT) begin
				due.push_back(e);
				return;
			end
			stg = r.fp ? cdna_pkg::STG_ONE :
				(r.len == cdna_pkg::STAGE_LONG ? cdna_pkg::STG_TWO : cdna_pkg::STG_THREE);
			want = clen == 0 ? cdna_pkg::STG_ONE :
				clen == cdna_pkg::STAGE_LONG ? cdna_pkg::STG_TWO :
				clen == cdna_pkg::STAGE2_LEN ? cdna_pkg::STG_THREE : cdna_pkg::STG_NONE;
			if (stg != want) begin
				restart();
				due.push_back(e);
				return;
			end
			for (int i = 0; i < r.len; i++)
				uid[((clen + i) & 15) * 8 +: 8] = r.chunk[i * 8 +: 8];
			clen = clen + r.len;
			if (stg == cdna_pkg::STG_ONE)
				ppref = r.pref;
			e.len = clen;
			e.lo = uid[63:0];
			e.hi = uid[127:64];
			if (clen == cdna_pkg::UID_BYTES) begin
				id = pick_id();
				e.oc = id != 0 ? cdna_pkg::OUT_ALLOC : cdna_pkg::OUT_NO_FREE;
				e.id = 7'(id);
				restart();
			end else begin
				e.oc = cdna_pkg::OUT_ECHO;
				last_ms = r.ms;
			end
			due.push_back(e);
		endfunction

		function void check(reply_t a);
			reply_t e;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: outcome %0d id %0d", a.oc, a.id);
				return;
			end
			e = due.pop_front();
			if (a.oc !== e.oc || a.id !== e.id || a.len !== e.len ||
					a.lo !== e.lo || a.hi !== e.hi) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %0d %0d %0d %h %h got %0d %0d %0d %h %h",
						e.oc, e.id, e.len, e.lo, e.hi, a.oc, a.id, a.len, a.lo, a.hi);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [31:0] now_ms;
	logic [6:0]  source_node;
	logic        is_broadcast;
	logic        first_part;
	logic [6:0]  preferred_node;
	logic [4:0]  chunk_len;
	logic [47:0] uid_chunk;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  outcome;
	logic [6:0]  reply_node_id;
	logic [4:0]  reply_uid_len;
	logic [63:0] reply_uid_low;
	logic [63:0] reply_uid_high;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	alloc_scoreboard sb = new();
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	bit           hold_req = 0;
	int           quiet = 0;
	int           sent = 0;
	logic [31:0]  cur_ms = 0;
	logic [127:0] uid_pool[8];

	can_dynamic_node_id_allocator_top i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready = 0;
				repeat (400) @(negedge clk);
			end
			out_ready = $urandom_range(0, 99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		reply_t a;
		if (out_valid && out_ready) begin
			a.oc = cdna_pkg::outcome_t'(outcome);
			a.id = reply_node_id;
			a.len = reply_uid_len;
			a.lo = reply_uid_low;
			a.hi = reply_uid_high;
			sb.check(a);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= 20000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic request_t mk(cdna_pkg::opcode_t op, logic [31:0] ms, logic [6:0] src,
			logic bc, logic fp, logic [6:0] pref, logic [4:0] len, logic [47:0] chunk);
		request_t r;
		r = '{op, ms, src, bc, fp, pref, len, chunk};
		return r;
	endfunction

	task automatic send_req(request_t r);
		@(negedge clk);
		opcode = r.op;
		now_ms = r.ms;
		source_node = r.src;
		is_broadcast = r.bc;
		first_part = r.fp;
		preferred_node = r.pref;
		chunk_len = r.len;
		uid_chunk = r.chunk;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note(r);
		sent++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic reg_write(cdna_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = 3'(idx) << 2;
		pwdata = val;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		if (idx == cdna_pkg::REG_TIMEOUT)
			sb.tmo = val[15:0];
		else
			sb.own = val[6:0];
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] step_ms();
		int span;
		span = sb.tmo > 20 ? 20 : sb.tmo;
		if ($urandom_range(0, 99) < 5)
			return cur_ms + sb.tmo + 1 + $urandom_range(0, 50);
		return cur_ms + $urandom_range(0, span);
	endfunction

	task automatic send_uid(logic [127:0] u, logic [6:0] pref, int broken);
		request_t r;
		for (int s = 0; s < 3; s++) begin
			cur_ms = step_ms();
			r = mk(cdna_pkg::OP_REQUEST, cur_ms, 7'd0, 1'b1, s == 0,
				s == 0 ? pref : 7'($urandom),
				s == 2 ? cdna_pkg::STAGE_SHORT : cdna_pkg::STAGE_LONG,
				s == 0 ? u[47:0] : s == 1 ? u[95:48] : {16'($urandom), u[127:96]});
			if (s == broken) begin
				case ($urandom_range(0, 2))
					0: r.fp = ~r.fp;
					1: r.len = 5'($urandom_range(0, 31));
					default: r.src = 7'($urandom_range(1, 127));
				endcase
			end
			send_req(r);
		end
	endtask

	task automatic random_phase(int n);
		request_t r;
		logic [127:0] u;
		int pick;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				u = $urandom_range(0, 2) == 0 ? uid_pool[$urandom_range(0, 7)] :
					{$urandom, $urandom, $urandom, $urandom};
				send_uid(u, $urandom_range(0, 3) == 0 ? 7'd0 : 7'($urandom),
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : -1);
			end else if (pick < 80) begin
				send_req(mk($urandom_range(0, 1) ? cdna_pkg::OP_ONLINE : cdna_pkg::OP_OFFLINE,
					$urandom, 7'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
					5'($urandom), 48'({$urandom, $urandom})));
			end else begin
				cur_ms = step_ms();
				r = mk(cdna_pkg::opcode_t'($urandom_range(0, 3)),
					$urandom_range(0, 3) == 0 ? $urandom : cur_ms,
					$urandom_range(0, 1) ? 7'd0 : 7'($urandom), 1'($urandom), 1'($urandom),
					7'($urandom), 5'($urandom), 48'({$urandom, $urandom}));
				send_req(r);
			end
		end
	endtask

	initial begin
		in_valid = 0;
		opcode = cdna_pkg::OP_REQUEST;
		now_ms = 0;
		source_node = 0;
		is_broadcast = 0;
		first_part = 0;
		preferred_node = 0;
		chunk_len = 0;
		uid_chunk = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		foreach (uid_pool[i]) uid_pool[i] = {$urandom, $urandom, $urandom, $urandom};
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		reg_write(cdna_pkg::REG_TIMEOUT, 500);
		reg_write(cdna_pkg::REG_OWN_ID, 1);
		send_req(mk(cdna_pkg::OP_UNUSED, 0, 0, 1, 1, 0, cdna_pkg::STAGE_LONG, 0));
		send_req(mk(cdna_pkg::OP_ONLINE, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk(cdna_pkg::OP_ONLINE, 0, 127, 0, 0, 0, 0, 0));
		send_req(mk(cdna_pkg::OP_OFFLINE, 0, 127, 0, 0, 0, 0, 0));
		send_req(mk(cdna_pkg::OP_ONLINE, 0, 2, 0, 0, 0, 0, 0));
		send_req(mk(cdna_pkg::OP_OFFLINE, 0, 1, 0, 0, 0, 0, 0));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 0, 0, 1, 0, cdna_pkg::STAGE_LONG, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 5, 1, 1, 0, cdna_pkg::STAGE_LONG, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 0, 1, 1, 0, 5'd17, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 0, 1, 1, 0, 5'd31, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 0, 1, 1, 0, 5'd0, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 0, 1, 1, 0, cdna_pkg::UID_BYTES, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 0, 0, 1, 0, 0, cdna_pkg::STAGE_LONG, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 10, 0, 1, 1, 7'd9, cdna_pkg::STAGE_SHORT, 48'h1234));
		send_req(mk(cdna_pkg::OP_REQUEST, 20, 0, 1, 0, 0, cdna_pkg::STAGE_LONG, 48'h5678));
		cur_ms = 100;
		send_uid(uid_pool[0], 0, -1);
		send_uid(uid_pool[0], 0, -1);
		send_uid(uid_pool[1], 7'd125, -1);
		send_uid(uid_pool[2], 7'd127, -1);
		send_uid(uid_pool[3], 7'd1, -1);
		send_req(mk(cdna_pkg::OP_REQUEST, cur_ms, 0, 1, 1, 0, cdna_pkg::STAGE_LONG, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, cur_ms + 501, 0, 1, 0, 0, cdna_pkg::STAGE_LONG, '1));
		send_req(mk(cdna_pkg::OP_REQUEST, 32'hFFFF_FFFF, 0, 1, 1, 0, cdna_pkg::STAGE_LONG, '0));
		random_phase(260);
		settle();

		reg_write(cdna_pkg::REG_TIMEOUT, 0);
		reg_write(cdna_pkg::REG_OWN_ID, 127);
		send_idle_pct = 52;
		random_phase(280);
		settle();

		reg_write(cdna_pkg::REG_TIMEOUT, 65535);
		reg_write(cdna_pkg::REG_OWN_ID, 64);
		send_idle_pct = 0;
		stall_pct = 52;
		hold_req = 1;
		random_phase(280);
		settle();

		reg_write(cdna_pkg::REG_TIMEOUT, $urandom_range(1, 65534));
		reg_write(cdna_pkg::REG_OWN_ID, $urandom_range(1, 127));
		send_idle_pct = 35;
		stall_pct = 35;
		random_phase(280);
		settle();

		if (sb.errors == 0 && sb.due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/cdna_pkg.sv
rtl/core/cdna_cell.sv
rtl/core/can_dynamic_node_id_allocator_top.sv
bench/can_dynamic_node_id_allocator_top_tb.sv
